// File: rtl/core/rwsf_pkg.sv
// shared types, codes and float helpers for the register word decode and scale block
// no dependencies
package rwsf_pkg;

    localparam logic [3:0] TYPE_U16    = 4'd0;
    localparam logic [3:0] TYPE_S16    = 4'd1;
    localparam logic [3:0] TYPE_U32_HI = 4'd2;
    localparam logic [3:0] TYPE_U32_LO = 4'd3;
    localparam logic [3:0] TYPE_S32_HI = 4'd4;
    localparam logic [3:0] TYPE_S32_LO = 4'd5;
    localparam logic [3:0] TYPE_F32_HI = 4'd6;
    localparam logic [3:0] TYPE_F32_LO = 4'd7;
    localparam logic [3:0] TYPE_BOOL   = 4'd8;

    localparam logic [1:0] CFG_DATA_TYPE = 2'd0;
    localparam logic [1:0] CFG_SCALE     = 2'd1;
    localparam logic [1:0] CFG_OFFSET    = 2'd2;

    localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
    localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

    // unpacked operand, mantissa normalized with leading one at bit 23
    typedef struct packed {
        logic              sign;
        logic              is_nan;
        logic              is_inf;
        logic              is_zero;
        logic signed [11:0] e;
        logic [23:0]       m;
    } t_fp_unp;

    // leading zero count, 32 when the word is zero
    function automatic logic [5:0] lzc32(input logic [31:0] v);
        logic [5:0] z;
        z = 6'd32;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                z = 6'(31 - i);
            end
        end
        return z;
    endfunction

    // round to nearest even and pack; m has its leading one at bit 26,
    // bits 2..0 are guard, round and sticky, value is 1.m * 2^e
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [26:0] m);
        logic signed [11:0] be;
        logic [11:0]        sh;
        logic [26:0]        mm;
        logic [30:0]        mag;
        logic               inc;
        be  = e + 12'sd127;
        sh  = 12'(12'sd1 - be);
        mm  = m;
        mag = '0;
        if (be >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (be >= 12'sd1) begin
            mag = {be[7:0], m[25:3]};
        end else begin
            // below the normal range: denormalize with sticky
            if (sh > 12'd26) begin
                mm = {26'd0, |m};
            end else begin
                mm = m >> sh[4:0];
                mm[0] = mm[0] | (|(m & ((27'd1 << sh[4:0]) - 27'd1)));
            end
            mag = {8'd0, mm[25:3]};
        end
        inc = mm[2] & (mm[1] | mm[0] | mm[3]);
        return {s, mag + 31'(inc)};
    endfunction

    function automatic t_fp_unp fp_unpack(input logic [31:0] f);
        t_fp_unp    u;
        logic [5:0] z;
        logic [23:0] t;
        u.sign    = f[31];
        u.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
        u.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
        u.is_zero = (f[30:0] == 31'd0);
        t = {1'b0, f[22:0]};
        z = lzc32({t, 8'hFF});
        if (f[30:23] != 8'd0) begin
            u.e = $signed({4'd0, f[30:23]}) - 12'sd127;
            u.m = {1'b1, f[22:0]};
        end else begin
            u.e = -12'sd126 - $signed({6'd0, z});
            u.m = t << z;
        end
        return u;
    endfunction

endpackage

// File: rtl/core/register_words_to_scaled_float_unit.sv
// top level: decodes one or two register words to a float, scales and offsets it
// depends on rwsf_pkg, rwsf_fmul and rwsf_fadd
//
// usage
//   input channel: word_first and word_second are taken at a clock edge with
//   i_start high and o_busy low; o_busy is always low, an item may enter in
//   every cycle
//   config: i_cfg_we writes i_cfg_wdata into data type (index 0), scale factor
//   (index 1) or add offset (index 2) at the clock edge; other indexes are dropped;
//   write only while no item is in flight
//   result: o_value_bits is shown for one cycle with o_valid high, right
//   after the sixth edge that follows the edge that took the item (taken at the
//   seventh); one result per item, in order
//   throughput: one item per clock; latency is set by the seven register stages
//   (decode, int to float, unpack, multiply, round, align and add, normalize)
//   reset: synchronous, clears the stage valid bits and loads data type u16,
//   scale 1.0 and offset 0.0; items in flight are dropped
//   the receiver cannot stall, so results never wait
//   any NaN result is given as 0x7fc00000
module register_words_to_scaled_float_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_word_first,
    input  logic [15:0] i_word_second,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_value_bits
);
    import rwsf_pkg::*;

    logic [3:0]  r_data_type;
    logic [31:0] r_scale, r_offset;

    logic        r_v1, r_v2;
    logic        r_is_int, r_sign;
    logic [31:0] r_mag, r_fbits;
    logic [31:0] r_raw;

    logic        n_is_int, n_sign;
    logic [31:0] n_mag, n_fbits, n_raw;
    logic [31:0] hi_word, lo_word;
    logic [5:0]  z;
    logic [31:0] nrm;

    logic        prod_valid;
    logic [31:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_type <= TYPE_U16;
            r_scale     <= FP_ONE;
            r_offset    <= 32'd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_v1 <= i_start & ~o_busy;
            r_v2 <= r_v1;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DATA_TYPE: r_data_type <= i_cfg_wdata[3:0];
                    CFG_SCALE:     r_scale     <= i_cfg_wdata;
                    CFG_OFFSET:    r_offset    <= i_cfg_wdata;
                    default:       ;
                endcase
            end
        end
    end

    // decode words to sign and magnitude, or to float bits
    always_comb begin
        hi_word  = {i_word_first, i_word_second};
        lo_word  = {i_word_second, i_word_first};
        n_is_int = 1'b1;
        n_sign   = 1'b0;
        n_mag    = {16'd0, i_word_first};
        n_fbits  = hi_word;
        case (r_data_type)
            TYPE_S16: begin
                n_sign = i_word_first[15];
                n_mag  = i_word_first[15] ? {16'd0, 16'(~i_word_first + 16'd1)}
                                          : {16'd0, i_word_first};
            end
            TYPE_U32_HI: n_mag = hi_word;
            TYPE_U32_LO: n_mag = lo_word;
            TYPE_S32_HI: begin
                n_sign = hi_word[31];
                n_mag  = hi_word[31] ? ~hi_word + 32'd1 : hi_word;
            end
            TYPE_S32_LO: begin
                n_sign = lo_word[31];
                n_mag  = lo_word[31] ? ~lo_word + 32'd1 : lo_word;
            end
            TYPE_F32_HI: begin
                n_is_int = 1'b0;
                n_fbits  = hi_word;
            end
            TYPE_F32_LO: begin
                n_is_int = 1'b0;
                n_fbits  = lo_word;
            end
            TYPE_BOOL: n_mag = {31'd0, |i_word_first};
            default:   n_mag = {16'd0, i_word_first};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_is_int <= n_is_int;
        r_sign   <= n_sign;
        r_mag    <= n_mag;
        r_fbits  <= n_fbits;
        r_raw    <= n_raw;
    end

    // integer to float with round to nearest even; float types pass through
    always_comb begin
        z   = lzc32(r_mag);
        nrm = r_mag << z;
        if (!r_is_int) begin
            n_raw = r_fbits;
        end else if (r_mag == 32'd0) begin
            n_raw = 32'd0;
        end else begin
            n_raw = fp_round(r_sign, 12'sd31 - $signed({6'd0, z}), {nrm[31:6], |nrm[5:0]});
        end
    end

    rwsf_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_a     (r_raw),
        .i_b     (r_scale),
        .o_valid (prod_valid),
        .o_prod  (prod)
    );

    rwsf_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_a     (prod),
        .i_b     (r_offset),
        .o_valid (o_valid),
        .o_sum   (o_value_bits)
    );

    assign o_busy = 1'b0;

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##7 o_valid)
        else $error("accepted item produced no result after seven cycles");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 7))
        else $error("result without an item accepted seven cycles earlier");

    a_nan_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_value_bits[30:23] == 8'hFF) && (o_value_bits[22:0] != 23'd0))
        |-> (o_value_bits == FP_QNAN))
        else $error("non canonical nan on the result");

endmodule

// File: rtl/core/rwsf_fmul.sv
// pipelined single precision multiplier, three register stages
// depends on rwsf_pkg
module rwsf_fmul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_prod
);
    import rwsf_pkg::*;

    t_fp_unp            r_ua, r_ub;
    logic [2:0]         r_v;
    logic [47:0]        r_p;
    logic signed [11:0] r_e;
    logic               r_s, r_nan, r_inf, r_zero;
    logic [31:0]        r_prod;
    logic [31:0]        n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ua   <= fp_unpack(i_a);
        r_ub   <= fp_unpack(i_b);
        r_p    <= r_ua.m * r_ub.m;
        r_e    <= r_ua.e + r_ub.e;
        r_s    <= r_ua.sign ^ r_ub.sign;
        r_nan  <= r_ua.is_nan | r_ub.is_nan | (r_ua.is_inf & r_ub.is_zero)
                | (r_ua.is_zero & r_ub.is_inf);
        r_inf  <= r_ua.is_inf | r_ub.is_inf;
        r_zero <= r_ua.is_zero | r_ub.is_zero;
        r_prod <= n_prod;
    end

    always_comb begin
        if (r_nan) begin
            n_prod = FP_QNAN;
        end else if (r_inf) begin
            n_prod = {r_s, 8'hFF, 23'd0};
        end else if (r_zero) begin
            n_prod = {r_s, 31'd0};
        end else if (r_p[47]) begin
            n_prod = fp_round(r_s, r_e + 12'sd1, {r_p[47:22], |r_p[21:0]});
        end else begin
            n_prod = fp_round(r_s, r_e, {r_p[46:21], |r_p[20:0]});
        end
    end

    assign o_valid = r_v[2];
    assign o_prod  = r_prod;

endmodule

// File: rtl/core/rwsf_fadd.sv
// pipelined single precision adder, align and add then normalize and round
// depends on rwsf_pkg
module rwsf_fadd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_valid,
    output logic [31:0] o_sum
);
    import rwsf_pkg::*;

    logic [1:0]  r_v;
    logic        r_spec, r_sign;
    logic [31:0] r_spec_bits;
    logic [27:0] r_sum;
    logic [7:0]  r_e;
    logic [31:0] r_out;

    logic        n_spec, n_sign;
    logic [31:0] n_spec_bits;
    logic [27:0] n_sum;
    logic [31:0] n_out;
    logic [31:0] big, sml;
    logic [7:0]  eb_big, eb_sml, d;
    logic [23:0] m_big, m_sml;
    logic [26:0] al_big, al_sml;
    logic        nan_a, nan_b, inf_a, inf_b;
    logic [5:0]  z;
    logic [27:0] nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_comb begin
        nan_a = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
        nan_b = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
        inf_a = (i_a[30:0] == 31'h7F80_0000);
        inf_b = (i_b[30:0] == 31'h7F80_0000);
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            sml = i_b;
        end else begin
            big = i_b;
            sml = i_a;
        end
        eb_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        eb_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        m_big  = {big[30:23] != 8'd0, big[22:0]};
        m_sml  = {sml[30:23] != 8'd0, sml[22:0]};
        d      = eb_big - eb_sml;
        al_big = {m_big, 3'b000};
        if (d > 8'd26) begin
            al_sml = {26'd0, |m_sml};
        end else begin
            al_sml = {m_sml, 3'b000} >> d[4:0];
            al_sml[0] = al_sml[0] | (|({m_sml, 3'b000} & ((27'd1 << d[4:0]) - 27'd1)));
        end
        if (big[31] == sml[31]) begin
            n_sum = {1'b0, al_big} + {1'b0, al_sml};
        end else begin
            n_sum = {1'b0, al_big} - {1'b0, al_sml};
        end
        n_sign      = big[31];
        n_spec      = 1'b1;
        n_spec_bits = '0;
        if (nan_a || nan_b || (inf_a && inf_b && (i_a[31] != i_b[31]))) begin
            n_spec_bits = FP_QNAN;
        end else if (inf_a) begin
            n_spec_bits = i_a;
        end else if (inf_b) begin
            n_spec_bits = i_b;
        end else if ((i_a[30:0] == 31'd0) && (i_b[30:0] == 31'd0)) begin
            n_spec_bits = {i_a[31] & i_b[31], 31'd0};
        end else if (i_a[30:0] == 31'd0) begin
            n_spec_bits = i_b;
        end else if (i_b[30:0] == 31'd0) begin
            n_spec_bits = i_a;
        end else begin
            n_spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spec      <= n_spec;
        r_spec_bits <= n_spec_bits;
        r_sign      <= n_sign;
        r_sum       <= n_sum;
        r_e         <= eb_big;
        r_out       <= n_out;
    end

    always_comb begin
        z   = lzc32({r_sum, 4'hF});
        nrm = r_sum << z;
        if (r_spec) begin
            n_out = r_spec_bits;
        end else if (r_sum == 28'd0) begin
            // exact cancellation rounds to plus zero
            n_out = 32'd0;
        end else begin
            n_out = fp_round(r_sign, $signed({4'd0, r_e}) - 12'sd126 - $signed({6'd0, z}),
                             {nrm[27:2], |nrm[1:0]});
        end
    end

    assign o_valid = r_v[1];
    assign o_sum   = r_out;

endmodule
